>>> rtl/ahsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsp_pkg
// Types and constants shared by the AU header section parser.
// ----------------------------------------------------------------------------
package ahsp_pkg;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [31:0] packet_timestamp;
		logic [15:0] packet_length;
	} ahsp_in_t;

	typedef struct packed {
		logic [15:0] au_length;
		logic [15:0] au_offset;
		logic [31:0] au_timestamp;
		logic        fragmented;
		logic        last_of_packet;
		logic [2:0]  status;
	} ahsp_out_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_SHORT     = 3'd2;
	localparam logic [2:0] ST_ZERO_AU   = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;

	localparam logic [2:0] REG_SIZE_BITS   = 3'd0;
	localparam logic [2:0] REG_INDEX_BITS  = 3'd1;
	localparam logic [2:0] REG_IDELTA_BITS = 3'd2;
	localparam logic [2:0] REG_CTS_BITS    = 3'd3;
	localparam logic [2:0] REG_DTS_BITS    = 3'd4;
	localparam logic [2:0] REG_AUX_BITS    = 3'd5;
	localparam logic [2:0] REG_TS_INC      = 3'd6;

	localparam int CFG_W    = 16;
	localparam int MAX_FLD  = 16;
	localparam int ENTRY_W  = 64;

	function automatic logic [4:0] wclamp(input logic [4:0] w);
		return (w > 5'(MAX_FLD)) ? 5'(MAX_FLD) : w;
	endfunction

endpackage

>>> rtl/ahsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ahsp_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/au_header_section_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// au_header_section_parser_top
// RFC 3640 AU header section parser: one payload byte per transfer in,
// one access unit descriptor or one status result per transfer out.
// ----------------------------------------------------------------------------
// Every accepted byte passes through FIN before the next byte is taken. A
// byte that reaches the AU header field walk first passes through PARSE, one
// step of the walk (one field extracted or one flag decision) per cycle.
// Parsed descriptors are written to a MAX_AUS deep RAM; after the last byte
// of a packet they are read back through its single read port, each through
// EMIT_RD and EMIT_WR, during which no byte is taken. Status results load
// in FIN. The output register lets a byte be taken while a result still waits.
module au_header_section_parser_top #(
	parameter int MAX_AUS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ahsp_pkg::ahsp_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ahsp_pkg::ahsp_out_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_addr,
	input  logic [ahsp_pkg::CFG_W-1:0] cfg_wdata
);
	import ahsp_pkg::*;

	localparam int AW = (MAX_AUS > 1) ? $clog2(MAX_AUS) : 1;
	localparam int CW = $clog2(MAX_AUS + 1);

	typedef enum logic [4:0] {
		C_IDLE    = 5'b00001,
		C_PARSE   = 5'b00010,
		C_FIN     = 5'b00100,
		C_EMIT_RD = 5'b01000,
		C_EMIT_WR = 5'b10000
	} ctl_t;

	typedef enum logic [5:0] {
		P_IDLE    = 6'b000001,
		P_LEN_LO  = 6'b000010,
		P_HEADER  = 6'b000100,
		P_AUX     = 6'b001000,
		P_PAYLOAD = 6'b010000,
		P_DISCARD = 6'b100000
	} phase_t;

	typedef enum logic [7:0] {
		F_SIZE = 8'b00000001,
		F_IDX  = 8'b00000010,
		F_CTSF = 8'b00000100,
		F_CTSD = 8'b00001000,
		F_DTSF = 8'b00010000,
		F_DTSD = 8'b00100000,
		F_NEXT = 8'b01000000,
		F_DONE = 8'b10000000
	} fsel_t;

	// configuration
	logic [4:0]  size_bits_q, cts_bits_q, dts_bits_q, aux_bits_q;
	logic [3:0]  index_bits_q, idelta_bits_q;
	logic [15:0] ts_inc_q;

	// parser state
	ctl_t        ctl_q;
	phase_t      phase_q;
	fsel_t       fsel_q;
	logic        from_header_q;
	logic        last_q;
	logic [15:0] hdr_total_q, hdr_used_q, accum_q, run_off_q, held_len_q;
	logic [15:0] bytes_q, dstart_q;
	logic [23:0] sr_q;
	logic [4:0]  sr_bits_q;
	logic [31:0] run_ts_q;
	logic [CW-1:0] au_count_q, emit_k_q;
	logic [2:0]  err_q;
	logic        frag_q;

	// output register
	logic        out_valid_q;
	ahsp_out_t   out_q;

	// combinational
	logic [4:0]  sb_w, cts_w, dts_w, aux_w, fw, shamt;
	logic [1:0]  flags;
	logic [5:0]  minf, need;
	logic [15:0] hdr_bytes, hdr_new, v, mask, first_len_lim;
	logic [16:0] used_plus;
	logic        over_h, short_sr, in_fire, out_free, exit_loop, step_fld;
	logic        out_load;
	logic [23:0] shifted;
	logic [16:0] inc_mul;
	logic [32:0] prod;
	logic [31:0] new_ts;
	logic [17:0] frag_sum;
	logic        frag_cond;
	logic [23:0] aux_sr;
	logic [4:0]  aux_shamt;
	logic [1:0]  aux_nb;
	logic [15:0] aux_val, aux_mask, aux_dstart;
	logic [23:0] aux_shifted;
	logic [17:0] aux_sum;
	logic [2:0]  fin_st;
	logic        ram_we, ram_re;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	assign sb_w  = wclamp(size_bits_q);
	assign cts_w = wclamp(cts_bits_q);
	assign dts_w = wclamp(dts_bits_q);
	assign aux_w = wclamp(aux_bits_q);
	assign flags = 2'(cts_bits_q != 5'd0) + 2'(dts_bits_q != 5'd0);
	assign minf  = 6'(sb_w) + 6'(index_bits_q) + 6'(flags);
	assign need  = 6'(sb_w) + 6'(idelta_bits_q) + 6'(flags);
	assign hdr_bytes = 16'((17'(hdr_total_q) + 17'd7) >> 3);
	assign hdr_new   = {accum_q[7:0], in_data.data_byte};

	assign in_fire  = in_valid && in_ready;
	assign in_ready = (ctl_q == C_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// field walk
	always_comb begin
		unique case (fsel_q)
			F_SIZE:  fw = sb_w;
			F_IDX:   fw = (au_count_q == '0) ? 5'(index_bits_q) : 5'(idelta_bits_q);
			F_CTSF:  fw = 5'd1;
			F_CTSD:  fw = cts_w;
			F_DTSF:  fw = 5'd1;
			F_DTSD:  fw = dts_w;
			default: fw = 5'd0;
		endcase
	end

	assign used_plus = 17'(hdr_used_q) + 17'(fw);
	assign over_h    = used_plus > 17'(hdr_total_q);
	assign short_sr  = fw > sr_bits_q;
	assign shamt     = sr_bits_q - fw;
	assign shifted   = sr_q >> shamt;
	assign mask      = 16'((17'd1 << fw) - 17'd1);
	assign v         = shifted[15:0] & mask;

	assign inc_mul   = 17'(v) + 17'd1;
	assign prod      = 33'(ts_inc_q) * 33'(inc_mul);
	assign new_ts    = (au_count_q == '0) ? run_ts_q : run_ts_q + prod[31:0];
	assign first_len_lim = held_len_q;
	assign frag_sum  = 18'(accum_q) + 18'd2 + 18'((6'(sb_w) + 6'd7) >> 3);
	assign frag_cond = frag_sum > 18'(first_len_lim);

	assign step_fld = !(fsel_q == F_DONE || err_q != ST_OK)
		&& !(fsel_q == F_CTSF && cts_bits_q == 5'd0)
		&& !(fsel_q == F_DTSF && dts_bits_q == 5'd0)
		&& (fsel_q != F_NEXT) && !over_h && !short_sr;
	assign exit_loop = (fsel_q == F_DONE) || (err_q != ST_OK)
		|| (!(fsel_q == F_CTSF && cts_bits_q == 5'd0)
		&& !(fsel_q == F_DTSF && dts_bits_q == 5'd0)
		&& (fsel_q != F_NEXT) && !over_h && short_sr);

	assign ram_we = (ctl_q == C_PARSE) && step_fld && (fsel_q == F_IDX)
		&& !((au_count_q == '0) && (accum_q == 16'd0))
		&& !((au_count_q != '0) && (au_count_q >= CW'(MAX_AUS)));
	assign ram_wdata = {accum_q, run_off_q, new_ts};
	assign ram_re = (ctl_q == C_EMIT_RD);

	// aux size field
	assign aux_sr      = {sr_q[15:0], in_data.data_byte};
	assign aux_nb      = 2'((6'(aux_w) + 6'd7) >> 3);
	assign aux_shamt   = 5'({aux_nb, 3'b000}) - aux_w;
	assign aux_shifted = aux_sr >> aux_shamt;
	assign aux_mask    = 16'((17'd1 << aux_w) - 17'd1);
	assign aux_val     = aux_shifted[15:0] & aux_mask;
	assign aux_sum     = 18'(aux_w) + 18'(aux_val) + 18'd7;
	assign aux_dstart  = 16'd2 + hdr_bytes + 16'(aux_sum >> 3);

	always_comb begin
		fin_st = err_q;
		if (err_q == ST_OK && (phase_q != P_PAYLOAD || au_count_q == '0)) begin
			fin_st = ST_TRUNCATED;
		end
	end

	assign out_load = out_free && (((ctl_q == C_FIN) && last_q && (phase_q != P_IDLE)
		&& (fin_st != ST_OK)) || (ctl_q == C_EMIT_WR));

	ahsp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_AUS),
		.ADDR_W(AW)
	) u_au_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(au_count_q[AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(emit_k_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_bits_q   <= 5'd13;
			index_bits_q  <= 4'd3;
			idelta_bits_q <= 4'd3;
			cts_bits_q    <= 5'd0;
			dts_bits_q    <= 5'd0;
			aux_bits_q    <= 5'd0;
			ts_inc_q      <= 16'd1024;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SIZE_BITS:   size_bits_q   <= cfg_wdata[4:0];
				REG_INDEX_BITS:  index_bits_q  <= cfg_wdata[3:0];
				REG_IDELTA_BITS: idelta_bits_q <= cfg_wdata[3:0];
				REG_CTS_BITS:    cts_bits_q    <= cfg_wdata[4:0];
				REG_DTS_BITS:    dts_bits_q    <= cfg_wdata[4:0];
				REG_AUX_BITS:    aux_bits_q    <= cfg_wdata[4:0];
				REG_TS_INC:      ts_inc_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q         <= C_IDLE;
			phase_q       <= P_IDLE;
			fsel_q        <= F_SIZE;
			from_header_q <= 1'b0;
			last_q        <= 1'b0;
			hdr_total_q   <= '0;
			hdr_used_q    <= '0;
			accum_q       <= '0;
			run_off_q     <= '0;
			held_len_q    <= '0;
			bytes_q       <= '0;
			dstart_q      <= '0;
			sr_q          <= '0;
			sr_bits_q     <= '0;
			run_ts_q      <= '0;
			au_count_q    <= '0;
			emit_k_q      <= '0;
			err_q         <= ST_OK;
			frag_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctl_q)
				C_IDLE: begin
					if (in_fire) begin
						last_q <= in_data.last_byte;
						ctl_q  <= C_FIN;
						if (in_data.first_byte) begin
							held_len_q  <= in_data.packet_length;
							run_ts_q    <= in_data.packet_timestamp;
							hdr_total_q <= '0;
							hdr_used_q  <= '0;
							sr_q        <= '0;
							sr_bits_q   <= '0;
							run_off_q   <= '0;
							au_count_q  <= '0;
							frag_q      <= 1'b0;
							bytes_q     <= '0;
							dstart_q    <= '0;
							fsel_q      <= F_SIZE;
							accum_q     <= {8'd0, in_data.data_byte};
							if (in_data.packet_length == 16'd0) begin
								err_q   <= ST_EMPTY;
								phase_q <= P_DISCARD;
							end else begin
								err_q   <= ST_OK;
								phase_q <= P_LEN_LO;
							end
						end else begin
							unique case (phase_q)
								P_LEN_LO: begin
									hdr_total_q <= hdr_new;
									accum_q     <= '0;
									if (hdr_new < 16'(minf)) begin
										err_q   <= ST_SHORT;
										phase_q <= P_DISCARD;
									end else begin
										from_header_q <= 1'b0;
										ctl_q         <= C_PARSE;
									end
								end
								P_HEADER: begin
									if (fsel_q != F_DONE) begin
										sr_q      <= {sr_q[15:0], in_data.data_byte};
										sr_bits_q <= sr_bits_q + 5'd8;
									end
									bytes_q       <= bytes_q + 16'd1;
									from_header_q <= 1'b1;
									ctl_q         <= C_PARSE;
								end
								P_AUX: begin
									sr_q    <= aux_sr;
									bytes_q <= bytes_q + 16'd1;
									if (bytes_q + 16'd1 >= 16'(aux_nb)) begin
										dstart_q <= aux_dstart;
										phase_q  <= P_PAYLOAD;
									end
								end
								default: ;
							endcase
						end
					end
				end
				C_PARSE: begin
					if (exit_loop) begin
						ctl_q <= C_FIN;
						if (err_q != ST_OK) begin
							phase_q <= P_DISCARD;
						end else if ((!from_header_q && hdr_total_q == 16'd0)
							|| (from_header_q && bytes_q >= hdr_bytes)) begin
							bytes_q <= '0;
							sr_q    <= '0;
							if (aux_w != 5'd0) begin
								phase_q <= P_AUX;
							end else begin
								dstart_q <= 16'd2 + hdr_bytes;
								phase_q  <= P_PAYLOAD;
							end
						end else if (!from_header_q) begin
							phase_q <= P_HEADER;
						end
					end else if (fsel_q == F_CTSF && cts_bits_q == 5'd0) begin
						fsel_q <= F_DTSF;
					end else if (fsel_q == F_DTSF && dts_bits_q == 5'd0) begin
						fsel_q <= F_NEXT;
					end else if (fsel_q == F_NEXT) begin
						fsel_q <= (hdr_total_q - hdr_used_q >= 16'(need)) ? F_SIZE : F_DONE;
					end else if (over_h) begin
						fsel_q <= F_DONE;
					end else begin
						sr_bits_q  <= sr_bits_q - fw;
						hdr_used_q <= used_plus[15:0];
						unique case (fsel_q)
							F_SIZE: begin
								accum_q <= v;
								fsel_q  <= F_IDX;
							end
							F_IDX: begin
								if (au_count_q == '0 && accum_q == 16'd0) begin
									err_q <= ST_ZERO_AU;
								end else if (au_count_q != '0
									&& au_count_q >= CW'(MAX_AUS)) begin
									err_q <= ST_OVERFLOW;
								end else begin
									run_ts_q   <= new_ts;
									run_off_q  <= run_off_q + accum_q;
									au_count_q <= au_count_q + CW'(1);
									if (au_count_q == '0 && frag_cond) begin
										frag_q <= 1'b1;
										fsel_q <= F_DONE;
									end else begin
										fsel_q <= F_CTSF;
									end
								end
							end
							F_CTSF:  fsel_q <= v[0] ? F_CTSD : F_DTSF;
							F_CTSD:  fsel_q <= F_DTSF;
							F_DTSF:  fsel_q <= v[0] ? F_DTSD : F_NEXT;
							default: fsel_q <= F_NEXT;
						endcase
					end
				end
				C_FIN: begin
					if (last_q && phase_q != P_IDLE) begin
						if (fin_st != ST_OK) begin
							if (out_free) begin
								out_q   <= {16'd0, 16'd0, 32'd0, 1'b0, 1'b1, fin_st};
								phase_q <= P_IDLE;
								ctl_q   <= C_IDLE;
							end
						end else begin
							phase_q  <= P_IDLE;
							emit_k_q <= '0;
							ctl_q    <= C_EMIT_RD;
						end
					end else begin
						ctl_q <= C_IDLE;
					end
				end
				C_EMIT_RD: begin
					ctl_q <= C_EMIT_WR;
				end
				C_EMIT_WR: begin
					if (out_free) begin
						out_q.au_length      <= ram_rdata[63:48];
						out_q.au_offset      <= ram_rdata[47:32] + dstart_q;
						out_q.au_timestamp   <= ram_rdata[31:0];
						out_q.fragmented     <= (emit_k_q == '0) && frag_q;
						out_q.last_of_packet <= (emit_k_q + CW'(1) == au_count_q);
						out_q.status         <= ST_OK;
						emit_k_q             <= emit_k_q + CW'(1);
						ctl_q <= (emit_k_q + CW'(1) == au_count_q) ? C_IDLE : C_EMIT_RD;
					end
				end
				default: ctl_q <= C_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		au_count_q <= CW'(MAX_AUS))
		else $error("descriptor count above capacity");

	a_we_in_parse: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ctl_q == C_PARSE) && (err_q == ST_OK))
		else $error("descriptor write outside field walk");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q == C_EMIT_RD || ctl_q == C_EMIT_WR) |-> emit_k_q < au_count_q)
		else $error("readout index past descriptor count");

	a_sr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sr_bits_q <= 5'd24)
		else $error("bit buffer overfilled");

	a_emit_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q == C_EMIT_RD) |-> phase_q == P_IDLE)
		else $error("readout while packet still open");

endmodule

>>> dv/ahsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsp_checker
// Watches the byte, descriptor and register ports of the AU header section
// parser, predicts every descriptor and status result from the accepted
// bytes, and compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module ahsp_checker import ahsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  ahsp_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  ahsp_out_t out_data,
	input  logic      cfg_we,
	input  logic [2:0] cfg_addr,
	input  logic [15:0] cfg_wdata,
	output int        errors,
	output int        pending
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_LEN_LO, PH_HEADER, PH_AUX, PH_PAYLOAD, PH_DISCARD
	} phase_e;

	typedef enum logic [2:0] {
		FS_SIZE, FS_IDX, FS_CTSF, FS_CTSD, FS_DTSF, FS_DTSD, FS_NEXT, FS_DONE
	} field_e;

	logic [4:0]  w_size, w_idx, w_idelta, w_cts, w_dts, w_aux;
	logic [15:0] ts_inc;

	phase_e      ph;
	field_e      fsel;
	int unsigned hdr_total, hdr_used, shreg, accum, run_ts, run_off, held_len;
	int unsigned au_cnt, sr_bits, err, frag, bytes_seen, data_start;
	logic [63:0] desc_mem [16];

	ahsp_out_t   desc_q [$];
	int          mism;

	function automatic int unsigned fw(input logic [4:0] w);
		return (w > 5'd16) ? 16 : int'(w);
	endfunction

	function automatic int unsigned flag_cnt();
		return ((w_cts != 0) ? 1 : 0) + ((w_dts != 0) ? 1 : 0);
	endfunction

	task automatic add_au(input int unsigned idx);
		int unsigned len;
		len = accum & 32'hFFFF;
		if (au_cnt == 0) begin
			if (len == 0) begin
				err = ST_ZERO_AU;
				return;
			end
			if (len + 2 + ((fw(w_size) + 7) >> 3) > held_len) begin
				frag = 1;
				fsel = FS_DONE;
			end
		end else begin
			if (au_cnt >= 16) begin
				err = ST_OVERFLOW;
				return;
			end
			run_ts = run_ts + int'(ts_inc) * (1 + idx);
		end
		desc_mem[au_cnt] = {len[15:0], run_off[15:0], run_ts[31:0]};
		run_off = (run_off + len) & 32'hFFFF;
		au_cnt++;
	endtask

	task automatic walk_fields();
		int unsigned w, v, need;
		while (fsel != FS_DONE && err == 0) begin
			w = 0;
			case (fsel)
				FS_SIZE: w = fw(w_size);
				FS_IDX:  w = fw(au_cnt == 0 ? w_idx : w_idelta);
				FS_CTSF: begin
					if (w_cts == 0) begin
						fsel = FS_DTSF;
						continue;
					end
					w = 1;
				end
				FS_CTSD: w = fw(w_cts);
				FS_DTSF: begin
					if (w_dts == 0) begin
						fsel = FS_NEXT;
						continue;
					end
					w = 1;
				end
				FS_DTSD: w = fw(w_dts);
				default: begin
					need = fw(w_size) + fw(w_idelta) + flag_cnt();
					fsel = (hdr_total - hdr_used >= need) ? FS_SIZE : FS_DONE;
					continue;
				end
			endcase
			if (hdr_used + w > hdr_total) begin
				fsel = FS_DONE;
				break;
			end
			if (w > sr_bits) break;
			v = (shreg >> (sr_bits - w)) & ((32'd1 << w) - 1);
			sr_bits -= w;
			hdr_used += w;
			case (fsel)
				FS_SIZE: begin
					accum = v;
					fsel = FS_IDX;
				end
				FS_IDX: begin
					add_au(v);
					if (fsel == FS_IDX) fsel = FS_CTSF;
				end
				FS_CTSF: fsel = v ? FS_CTSD : FS_DTSF;
				FS_CTSD: fsel = FS_DTSF;
				FS_DTSF: fsel = v ? FS_DTSD : FS_NEXT;
				default: fsel = FS_NEXT;
			endcase
		end
	endtask

	task automatic end_header();
		bytes_seen = 0;
		shreg = 0;
		if (fw(w_aux) > 0) begin
			ph = PH_AUX;
		end else begin
			data_start = 2 + ((hdr_total + 7) >> 3);
			ph = PH_PAYLOAD;
		end
	endtask

	task automatic predict_byte(input ahsp_in_t d);
		int unsigned b, minf, a, nb, val, st;
		ahsp_out_t r;
		b = d.data_byte;
		if (d.first_byte) begin
			held_len = d.packet_length;
			run_ts = d.packet_timestamp;
			hdr_total = 0;
			hdr_used = 0;
			shreg = 0;
			run_off = 0;
			au_cnt = 0;
			sr_bits = 0;
			err = 0;
			frag = 0;
			bytes_seen = 0;
			data_start = 0;
			fsel = FS_SIZE;
			accum = b;
			if (held_len == 0) begin
				err = ST_EMPTY;
				ph = PH_DISCARD;
			end else begin
				ph = PH_LEN_LO;
			end
		end else if (ph == PH_LEN_LO) begin
			minf = fw(w_size) + fw(w_idx) + flag_cnt();
			hdr_total = ((accum & 8'hFF) << 8) | b;
			accum = 0;
			if (hdr_total < minf) begin
				err = ST_SHORT;
				ph = PH_DISCARD;
			end else begin
				walk_fields();
				if (err != 0) ph = PH_DISCARD;
				else if (hdr_total == 0) end_header();
				else ph = PH_HEADER;
			end
		end else if (ph == PH_HEADER) begin
			if (fsel != FS_DONE) begin
				shreg = ((shreg << 8) | b) & 32'hFFFFFF;
				sr_bits += 8;
			end
			bytes_seen++;
			walk_fields();
			if (err != 0) ph = PH_DISCARD;
			else if (bytes_seen >= ((hdr_total + 7) >> 3)) end_header();
		end else if (ph == PH_AUX) begin
			a = fw(w_aux);
			nb = (a + 7) >> 3;
			shreg = ((shreg << 8) | b) & 32'hFFFFFF;
			bytes_seen++;
			if (bytes_seen >= nb) begin
				val = (shreg >> (nb * 8 - a)) & ((32'd1 << a) - 1);
				data_start = 2 + ((hdr_total + 7) >> 3) + ((a + val + 7) >> 3);
				ph = PH_PAYLOAD;
			end
		end

		if (d.last_byte && ph != PH_IDLE) begin
			st = err;
			if (st == 0 && (ph != PH_PAYLOAD || au_cnt == 0)) st = ST_TRUNCATED;
			if (st != 0) begin
				r = '0;
				r.last_of_packet = 1'b1;
				r.status = st[2:0];
				desc_q.push_back(r);
			end else begin
				for (int k = 0; k < au_cnt && k < 16; k++) begin
					r.au_length = desc_mem[k][63:48];
					r.au_offset = desc_mem[k][47:32] + data_start[15:0];
					r.au_timestamp = desc_mem[k][31:0];
					r.fragmented = (k == 0 && frag != 0);
					r.last_of_packet = (k + 1 == au_cnt);
					r.status = ST_OK;
					desc_q.push_back(r);
				end
			end
			ph = PH_IDLE;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ahsp_out_t e;
		if (!arst_n) begin
			w_size = 13;
			w_idx = 3;
			w_idelta = 3;
			w_cts = 0;
			w_dts = 0;
			w_aux = 0;
			ts_inc = 1024;
			ph = PH_IDLE;
			fsel = FS_SIZE;
			hdr_total = 0;
			hdr_used = 0;
			shreg = 0;
			accum = 0;
			run_ts = 0;
			run_off = 0;
			held_len = 0;
			au_cnt = 0;
			sr_bits = 0;
			err = 0;
			frag = 0;
			bytes_seen = 0;
			data_start = 0;
			desc_q.delete();
			mism = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_SIZE_BITS:   w_size = cfg_wdata[4:0];
					REG_INDEX_BITS:  w_idx = {1'b0, cfg_wdata[3:0]};
					REG_IDELTA_BITS: w_idelta = {1'b0, cfg_wdata[3:0]};
					REG_CTS_BITS:    w_cts = cfg_wdata[4:0];
					REG_DTS_BITS:    w_dts = cfg_wdata[4:0];
					REG_AUX_BITS:    w_aux = cfg_wdata[4:0];
					REG_TS_INC:      ts_inc = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (desc_q.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("unexpected result transfer: %h", out_data);
				end else begin
					e = desc_q.pop_front();
					if (out_data.au_length !== e.au_length ||
					    out_data.au_offset !== e.au_offset ||
					    out_data.au_timestamp !== e.au_timestamp ||
					    out_data.fragmented !== e.fragmented ||
					    out_data.last_of_packet !== e.last_of_packet ||
					    out_data.status !== e.status) begin
						mism++;
						if (mism <= 10)
							$display("mismatch: expected %h actual %h", e, out_data);
					end
				end
			end
			if (in_valid && in_ready)
				predict_byte(in_data);
			errors <= mism;
			pending <= desc_q.size();
		end
	end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives RTP payload packets into the AU header section parser: directed
// error and edge packets, then random well-formed, broken and noise packets
// over several register settings, with random idling on both sides until the last setting.
// ----------------------------------------------------------------------------
module tb;
	import ahsp_pkg::*;

	localparam int LIMIT = 300000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	ahsp_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	ahsp_out_t   out_data;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;

	int          errors;
	int          pending;
	int          cycles = 0;
	bit          idle_en = 1'b1;
	bit          hold_req = 1'b0;
	int          sent = 0;

	int unsigned c_size = 13, c_idx = 3, c_idelta = 3, c_cts = 0, c_dts = 0, c_aux = 0;

	logic [7:0]  pkt [$];
	bit          bq [$];

	au_header_section_parser_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	ahsp_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input ahsp_in_t d);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_data <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic send_pkt(input logic [31:0] ts, input logic [15:0] len, input bit with_last);
		ahsp_in_t d;
		for (int i = 0; i < pkt.size(); i++) begin
			d.data_byte = pkt[i];
			d.first_byte = (i == 0);
			d.last_byte = with_last && (i == pkt.size() - 1);
			d.packet_timestamp = ts;
			d.packet_length = len;
			send_byte(d);
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_cfg(input int unsigned v [7]);
		wait_drained();
		repeat (60) @(posedge clk);
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= 3'(i);
			cfg_wdata <= 16'(v[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		c_size = v[0];
		c_idx = v[1];
		c_idelta = v[2];
		c_cts = v[3];
		c_dts = v[4];
		c_aux = v[5];
	endtask

	task automatic put_bits(input int unsigned v, input int unsigned w);
		for (int i = int'(w) - 1; i >= 0; i--)
			bq.push_back(1'((v >> i) & 1));
	endtask

	// kind 0 well-formed, 1 broken, 2 noise
	task automatic random_pkt(input int kind);
		int unsigned nau, sz, maxsz, hbits, hbytes, av, sum, len, f;
		logic [7:0] b;
		logic [31:0] ts;
		ahsp_in_t d;
		ts = $urandom;
		if (kind == 2) begin
			repeat ($urandom_range(1, 4)) begin
				d = ahsp_in_t'(58'({$urandom, $urandom}));
				d.first_byte = ($urandom_range(0, 3) == 0);
				send_byte(d);
			end
			in_valid <= 1'b0;
			return;
		end
		bq.delete();
		pkt.delete();
		nau = ($urandom_range(0, 14) == 0) ? 17 : $urandom_range(1, 3);
		maxsz = (c_size >= 3) ? 6 : (1 << c_size) - 1;
		sum = 0;
		for (int k = 0; k < nau; k++) begin
			sz = $urandom_range((k == 0) ? 1 : 0, maxsz);
			sum += sz;
			put_bits(sz, c_size);
			put_bits($urandom, (k == 0) ? c_idx : c_idelta);
			if (c_cts != 0) begin
				f = $urandom_range(0, 1);
				put_bits(f, 1);
				if (f) put_bits($urandom, c_cts);
			end
			if (c_dts != 0) begin
				f = $urandom_range(0, 1);
				put_bits(f, 1);
				if (f) put_bits($urandom, c_dts);
			end
		end
		hbits = bq.size();
		if (kind == 1 && $urandom_range(0, 1)) begin
			if ($urandom_range(0, 1)) hbits = $urandom_range(0, hbits + 8);
			else sz = 0;
			if (sz == 0 && hbits == bq.size()) begin
				for (int i = 0; i < c_size; i++) bq[i] = 1'b0;
			end
		end
		pkt.push_back(hbits[15:8]);
		pkt.push_back(hbits[7:0]);
		hbytes = (hbits + 7) >> 3;
		for (int j = 0; j < hbytes; j++) begin
			for (int i = 0; i < 8; i++)
				b[7 - i] = (j * 8 + i < bq.size()) ? bq[j * 8 + i]
					: 1'($urandom_range(0, 1));
			pkt.push_back(b);
		end
		if (c_aux != 0) begin
			bq.delete();
			av = $urandom_range(0, 20);
			put_bits(av, c_aux);
			put_bits($urandom, av);
			while (bq.size() % 8 != 0) bq.push_back(1'($urandom_range(0, 1)));
			for (int j = 0; j < bq.size() / 8; j++) begin
				for (int i = 0; i < 8; i++) b[7 - i] = bq[j * 8 + i];
				pkt.push_back(b);
			end
		end
		repeat (sum) pkt.push_back(8'($urandom));
		len = pkt.size();
		if ($urandom_range(0, 5) == 0) len = $urandom_range(1, 6);
		if (kind == 1) begin
			case ($urandom_range(0, 3))
				0: len = $urandom;
				1: len = 0;
				2: repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
				default: ;
			endcase
		end
		send_pkt(ts, 16'(len), !(kind == 1 && $urandom_range(0, 5) == 0));
	endtask

	task automatic random_phase(input int bytes);
		int stop;
		stop = sent + bytes;
		while (sent < stop) begin
			case ($urandom_range(0, 9))
				0, 1:    random_pkt(1);
				2:       random_pkt(2);
				default: random_pkt(0);
			endcase
		end
	endtask

	initial begin
		int unsigned v [7];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty packet
		pkt = '{8'h00};
		send_pkt(32'hFFFF_FFFF, 16'h0000, 1'b1);
		// stray byte carrying last
		pkt = '{8'hFF};
		in_data <= '{8'hFF, 1'b0, 1'b1, 32'h0, 16'h0};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
		// header shorter than one AU header
		pkt = '{8'h00, 8'h05};
		send_pkt(32'h1234_5678, 16'h0002, 1'b1);
		// zero size first AU
		pkt = '{8'h00, 8'h10, 8'h00, 8'h00};
		send_pkt(32'h0, 16'h000A, 1'b1);
		// ends inside the length field
		pkt = '{8'h00};
		send_pkt(32'h0, 16'h0005, 1'b1);
		// abandoned packet, then a good one
		pkt = '{8'h00, 8'h10};
		send_pkt(32'h0, 16'hFFFF, 1'b0);
		pkt = '{8'h00, 8'h10, 8'h00, 8'h10, 8'hAA, 8'hBB};
		send_pkt(32'hFFFF_FFFF, 16'h0006, 1'b1);
		// fragmented first AU
		pkt = '{8'h00, 8'h10, 8'h00, 8'h10, 8'hAA};
		send_pkt(32'h0000_0000, 16'h0005, 1'b1);

		random_phase(35);

		v = '{16, 8, 8, 16, 16, 16, 65535};
		write_cfg(v);
		hold_req = 1'b1;
		random_phase(45);

		v = '{1, 0, 0, 0, 0, 0, 1};
		write_cfg(v);
		random_phase(15);
		wait_drained();
		random_phase(15);

		v = '{$urandom_range(1, 16), $urandom_range(0, 8), $urandom_range(0, 8),
		      $urandom_range(0, 16), $urandom_range(0, 16), $urandom_range(0, 16),
		      $urandom_range(1, 65535)};
		write_cfg(v);
		random_phase(40);

		v = '{$urandom_range(1, 16), $urandom_range(0, 8), $urandom_range(0, 8),
		      $urandom_range(0, 16), $urandom_range(0, 16), $urandom_range(0, 16),
		      $urandom_range(1, 65535)};
		write_cfg(v);
		idle_en = 1'b0;
		random_phase(35);

		wait_drained();
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
